// ===== design/line_intersection_point_core_assert.svh =====
// ----------------------------------------------------------------------------
// line_intersection_point_core_assert.svh
// Assertion macros used by the checker file of the intersection core.
// ----------------------------------------------------------------------------
`ifndef LINE_INTERSECTION_POINT_CORE_ASSERT_SVH
`define LINE_INTERSECTION_POINT_CORE_ASSERT_SVH

// clocked assertion that is switched off while reset is high
`define LIP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define LIP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/lip_pkg.sv =====
// ----------------------------------------------------------------------------
// lip_pkg
// Types and fixed constants of the line intersection core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lip_pkg;

   // field and datapath widths
   localparam int unsigned DATA_W      = 32;
   localparam int unsigned THR_W       = 31;
   localparam int unsigned DET_W       = 64;
   localparam int unsigned NUM_W       = 65;
   localparam int unsigned PROD_W      = 96;
   localparam int unsigned QUO_BITS    = 41;
   localparam int unsigned SUM_W       = QUO_BITS + 2;
   localparam int unsigned QUEUE_DEPTH = 4;

   // register file
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam logic        REG_DET_THRESHOLD = 1'b0;
   localparam logic [THR_W-1:0] THR_RESET = 31'd655;

   // saturation limits
   localparam logic [DATA_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] COORD_MIN = 32'h8000_0000;

   // classified item passed from the front end to the back end
   typedef struct packed {
      logic signed [DATA_W-1:0] p1x;
      logic signed [DATA_W-1:0] p1y;
      logic [DATA_W-1:0]        ax_mag;
      logic [DATA_W-1:0]        ay_mag;
      logic                     neg_x;
      logic                     neg_y;
      logic [DET_W-1:0]         det_mag;
      logic [NUM_W-1:0]         num_mag;
      logic                     par;
   } lip_item_type;

   // one coordinate lane inside the divider pipe
   typedef struct packed {
      logic [DET_W-1:0]         rem;
      logic [QUO_BITS-1:0]      low;
      logic [QUO_BITS-1:0]      quo;
      logic signed [DATA_W-1:0] p;
      logic                     neg;
      logic                     sat;
   } lip_lane_type;

endpackage

`default_nettype wire

// ===== design/lip_req_if.sv =====
// ----------------------------------------------------------------------------
// lip_req_if
// Input channel: two lines, each a point and a direction, per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lip_req_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  first_point_x;
   logic signed [31:0]  first_point_y;
   logic signed [31:0]  first_dir_x;
   logic signed [31:0]  first_dir_y;
   logic signed [31:0]  second_point_x;
   logic signed [31:0]  second_point_y;
   logic signed [31:0]  second_dir_x;
   logic signed [31:0]  second_dir_y;

   modport source (
      output valid, first_point_x, first_point_y, first_dir_x, first_dir_y,
             second_point_x, second_point_y, second_dir_x, second_dir_y,
      input  ready
   );
   modport sink (
      input  valid, first_point_x, first_point_y, first_dir_x, first_dir_y,
             second_point_x, second_point_y, second_dir_x, second_dir_y,
      output ready
   );
endinterface

`default_nettype wire

// ===== design/lip_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lip_rsp_if
// Result channel: intersection point and flags, one beat per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lip_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  cross_x;
   logic signed [31:0]  cross_y;
   logic                is_parallel;
   logic                overflowed;

   modport source (
      output valid, cross_x, cross_y, is_parallel, overflowed,
      input  ready
   );
   modport sink (
      input  valid, cross_x, cross_y, is_parallel, overflowed,
      output ready
   );
endinterface

`default_nettype wire

// ===== design/line_intersection_point_core.sv =====
// ----------------------------------------------------------------------------
// line_intersection_point_core
// Intersection of two lines given as point plus direction, fixed point.
// ----------------------------------------------------------------------------
//  channel   dir   handshake          beat contents
//  req       in    valid / ready      two points, two directions
//  rsp       out   valid / ready      cross_x, cross_y, is_parallel, overflowed
//  csr       in    apb psel/penable   det_threshold at byte address 0
//
//  one request enters per cycle while the core is not stalled; its result
//  passes 4 front stages, one queue slot, 3 multiply stages, a divider
//  entry stage, 41 restoring divider stages (one quotient bit per stage)
//  and the result register
//  a four-entry queue separates front and back, so requests keep flowing
//  while rsp is stalled until the queue fills; reset empties all pipes
//  and the queue and loads det_threshold with 655
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module line_intersection_point_core #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   lip_req_if.sink                            req,
   lip_rsp_if.source                          rsp,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [lip_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   logic [lip_pkg::THR_W-1:0] thr_ff, thr_in;
   logic                      reg_sel;
   logic                      q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
   lip_pkg::lip_item_type     q_push_item, q_pop_item;

   // register decode on the word index
   assign reg_sel = (paddr[lip_pkg::CSR_ADDR_W-1] == lip_pkg::REG_DET_THRESHOLD);
   assign pready  = 1'b1;
   assign prdata  = reg_sel ? {1'b0, thr_ff} : 32'd0;

   always_comb begin
      thr_in = thr_ff;
      if (psel && penable && pwrite && reg_sel) begin
         thr_in = pwdata[lip_pkg::THR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= lip_pkg::THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   // front end: accept and classify
   lip_front #(
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .det_threshold(thr_ff),
      .push_valid   (q_push_valid),
      .push_item    (q_push_item),
      .push_ready   (q_push_ready)
   );

   // decoupling queue
   lip_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(q_push_valid),
      .push_item (q_push_item),
      .push_ready(q_push_ready),
      .pop_valid (q_pop_valid),
      .pop_item  (q_pop_item),
      .pop_ready (q_pop_ready)
   );

   // back end: scale, divide, saturate
   lip_back #(
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_valid(q_pop_valid),
      .pop_item (q_pop_item),
      .pop_ready(q_pop_ready),
      .rsp      (rsp)
   );

endmodule

`default_nettype wire

// ===== design/lip_front.sv =====
// ----------------------------------------------------------------------------
// lip_front
// Accepts request beats, forms determinant and numerator, classifies parallel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lip_front #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   lip_req_if.sink                       req,
   input  logic [lip_pkg::THR_W-1:0]     det_threshold,
   output logic                          push_valid,
   output lip_pkg::lip_item_type         push_item,
   input  logic                          push_ready
);

   localparam int unsigned DW = lip_pkg::DATA_W;

   logic       adv;
   logic [3:0] vld_ff;
   logic [3:0] vld_in;

   // stage 0: operands and point differences
   logic signed [DW-1:0] p1x_s0_ff, p1y_s0_ff, a1x_s0_ff, a1y_s0_ff, a2x_s0_ff, a2y_s0_ff;
   logic signed [DW:0]   dx_s0_ff, dy_s0_ff, dx_s0_in, dy_s0_in;

   // stage 1: products
   logic signed [DW-1:0] p1x_s1_ff, p1y_s1_ff, a1x_s1_ff, a1y_s1_ff;
   logic signed [63:0]   m0_s1_ff, m1_s1_ff, m0_s1_in, m1_s1_in;
   logic signed [64:0]   n0_s1_ff, n1_s1_ff, n0_s1_in, n1_s1_in;

   // stage 2: determinant and numerator
   logic signed [DW-1:0] p1x_s2_ff, p1y_s2_ff, a1x_s2_ff, a1y_s2_ff;
   logic signed [63:0]   det_s2_ff, det_s2_in;
   logic signed [64:0]   num_s2_ff, num_s2_in;

   // stage 3: magnitudes, signs and classification
   lip_pkg::lip_item_type item_s3_ff, item_s3_in;
   logic [lip_pkg::DET_W-1:0] thr_scaled;
   logic                      det_neg;
   logic                      num_neg;

   // whole front pipe holds while the last stage cannot hand over
   assign adv        = !(vld_ff[3] && !push_ready);
   assign req.ready  = adv;
   assign push_valid = vld_ff[3];
   assign push_item  = item_s3_ff;
   assign vld_in     = {vld_ff[2:0], req.valid};

   // point differences
   always_comb begin
      dx_s0_in = $signed({req.second_point_x[DW-1], req.second_point_x})
               - $signed({req.first_point_x[DW-1], req.first_point_x});
      dy_s0_in = $signed({req.second_point_y[DW-1], req.second_point_y})
               - $signed({req.first_point_y[DW-1], req.first_point_y});
   end

   // cross products
   always_comb begin
      m0_s1_in = 64'(a2x_s0_ff) * 64'(a1y_s0_ff);
      m1_s1_in = 64'(a1x_s0_ff) * 64'(a2y_s0_ff);
      n0_s1_in = 65'(dy_s0_ff) * 65'(a2x_s0_ff);
      n1_s1_in = 65'(dx_s0_ff) * 65'(a2y_s0_ff);
   end

   // differences of products, both fit without growth
   always_comb begin
      det_s2_in = m0_s1_ff - m1_s1_ff;
      num_s2_in = n0_s1_ff - n1_s1_ff;
   end

   // classification
   always_comb begin
      det_neg    = det_s2_ff[63];
      num_neg    = num_s2_ff[64];
      thr_scaled = lip_pkg::DET_W'(det_threshold) << FRAC_BITS;
      item_s3_in.p1x     = p1x_s2_ff;
      item_s3_in.p1y     = p1y_s2_ff;
      item_s3_in.ax_mag  = a1x_s2_ff[DW-1] ? DW'(-a1x_s2_ff) : DW'(a1x_s2_ff);
      item_s3_in.ay_mag  = a1y_s2_ff[DW-1] ? DW'(-a1y_s2_ff) : DW'(a1y_s2_ff);
      item_s3_in.neg_x   = num_neg ^ a1x_s2_ff[DW-1] ^ det_neg;
      item_s3_in.neg_y   = num_neg ^ a1y_s2_ff[DW-1] ^ det_neg;
      item_s3_in.det_mag = det_neg ? 64'(-det_s2_ff) : 64'(det_s2_ff);
      item_s3_in.num_mag = num_neg ? 65'(-num_s2_ff) : 65'(num_s2_ff);
      item_s3_in.par     = (det_s2_ff == '0) || (item_s3_in.det_mag < thr_scaled);
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // payload pipe
   always_ff @(posedge clock) begin
      if (adv) begin
         p1x_s0_ff  <= req.first_point_x;
         p1y_s0_ff  <= req.first_point_y;
         a1x_s0_ff  <= req.first_dir_x;
         a1y_s0_ff  <= req.first_dir_y;
         a2x_s0_ff  <= req.second_dir_x;
         a2y_s0_ff  <= req.second_dir_y;
         dx_s0_ff   <= dx_s0_in;
         dy_s0_ff   <= dy_s0_in;
         p1x_s1_ff  <= p1x_s0_ff;
         p1y_s1_ff  <= p1y_s0_ff;
         a1x_s1_ff  <= a1x_s0_ff;
         a1y_s1_ff  <= a1y_s0_ff;
         m0_s1_ff   <= m0_s1_in;
         m1_s1_ff   <= m1_s1_in;
         n0_s1_ff   <= n0_s1_in;
         n1_s1_ff   <= n1_s1_in;
         p1x_s2_ff  <= p1x_s1_ff;
         p1y_s2_ff  <= p1y_s1_ff;
         a1x_s2_ff  <= a1x_s1_ff;
         a1y_s2_ff  <= a1y_s1_ff;
         det_s2_ff  <= det_s2_in;
         num_s2_ff  <= num_s2_in;
         item_s3_ff <= item_s3_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/lip_queue.sv =====
// ----------------------------------------------------------------------------
// lip_queue
// Small FIFO of classified items between the front and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lip_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  lip_pkg::lip_item_type push_item,
   output logic                  push_ready,
   output logic                  pop_valid,
   output lip_pkg::lip_item_type pop_item,
   input  logic                  pop_ready
);

   localparam int unsigned DEPTH = lip_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   lip_pkg::lip_item_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== design/lip_back.sv =====
// ----------------------------------------------------------------------------
// lip_back
// Scales the numerator, divides by the determinant and saturates the point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lip_back #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   input  lip_pkg::lip_item_type pop_item,
   output logic                  pop_ready,
   lip_rsp_if.source             rsp
);

   localparam int unsigned DW     = lip_pkg::DATA_W;
   localparam int unsigned QB     = lip_pkg::QUO_BITS;
   localparam int unsigned PW     = lip_pkg::PROD_W;
   localparam int unsigned SW     = lip_pkg::SUM_W;
   localparam int unsigned DTW    = lip_pkg::DET_W;
   localparam logic [DW-1:0] NEG_ONE = ~((DW'(1) << FRAC_BITS) - DW'(1));

   // one restoring step: one quotient bit
   function automatic lip_pkg::lip_lane_type div_step(lip_pkg::lip_lane_type l,
                                                      logic [DTW-1:0] d);
      lip_pkg::lip_lane_type r;
      logic [DTW:0] shifted;
      logic [DTW:0] trial;
      shifted = {l.rem, l.low[QB-1]};
      trial   = shifted - {1'b0, d};
      r       = l;
      r.low   = {l.low[QB-2:0], 1'b0};
      if (!trial[DTW]) begin
         r.rem = trial[DTW-1:0];
         r.quo = {l.quo[QB-2:0], 1'b1};
      end else begin
         r.rem = shifted[DTW-1:0];
         r.quo = {l.quo[QB-2:0], 1'b0};
      end
      return r;
   endfunction

   // p +/- q with saturation; top bit is the overflow flag
   function automatic logic [DW:0] finish(lip_pkg::lip_lane_type l);
      logic [SW-1:0] pe;
      logic [SW-1:0] qe;
      logic [SW-1:0] sum;
      logic          hi_ovf;
      logic          lo_ovf;
      logic [DW:0]   r;
      pe     = {{(SW - DW){l.p[DW-1]}}, l.p};
      qe     = {2'b00, l.quo};
      sum    = l.neg ? pe - qe : pe + qe;
      hi_ovf = !sum[SW-1] && (sum[SW-2:DW-1] != '0);
      lo_ovf = sum[SW-1] && (sum[SW-2:DW-1] != '1);
      if (l.sat) begin
         r = {1'b1, (l.neg ? lip_pkg::COORD_MIN : lip_pkg::COORD_MAX)};
      end else if (hi_ovf) begin
         r = {1'b1, lip_pkg::COORD_MAX};
      end else if (lo_ovf) begin
         r = {1'b1, lip_pkg::COORD_MIN};
      end else begin
         r = {1'b0, sum[DW-1:0]};
      end
      return r;
   endfunction

   logic adv;

   // entry, partial products, full products
   logic                  vld_b0_ff, vld_b1_ff, vld_b2_ff;
   lip_pkg::lip_item_type item_b0_ff, item_b1_ff, item_b2_ff;
   logic [63:0]           lo_x_b1_ff, lo_y_b1_ff, lo_x_b1_in, lo_y_b1_in;
   logic [64:0]           hi_x_b1_ff, hi_y_b1_ff, hi_x_b1_in, hi_y_b1_in;
   logic [PW-1:0]         prod_x_b2_ff, prod_y_b2_ff, prod_x_b2_in, prod_y_b2_in;

   // divider pipe
   lip_pkg::lip_lane_type lane_x_ff [QB+1];
   lip_pkg::lip_lane_type lane_y_ff [QB+1];
   lip_pkg::lip_lane_type lane_x_in [QB+1];
   lip_pkg::lip_lane_type lane_y_in [QB+1];
   logic [DTW-1:0]        dvs_ff [QB+1];
   logic [DTW-1:0]        dvs_in [QB+1];
   logic [QB:0]           dpar_ff, dpar_in;
   logic [QB:0]           dvld_ff, dvld_in;

   // result register
   logic                  out_vld_ff;
   logic [DW-1:0]         cross_x_ff, cross_y_ff, cross_x_in, cross_y_in;
   logic                  par_ff, ovf_ff, ovf_in;
   logic [DW:0]           fin_x, fin_y;

   // back pipe holds only while a result waits
   assign adv             = !(out_vld_ff && !rsp.ready);
   assign pop_ready       = adv;
   assign rsp.valid       = out_vld_ff;
   assign rsp.cross_x     = cross_x_ff;
   assign rsp.cross_y     = cross_y_ff;
   assign rsp.is_parallel = par_ff;
   assign rsp.overflowed  = ovf_ff;

   // numerator magnitude times direction magnitude, split in halves
   always_comb begin
      lo_x_b1_in = 64'(item_b0_ff.num_mag[31:0]) * 64'(item_b0_ff.ax_mag);
      lo_y_b1_in = 64'(item_b0_ff.num_mag[31:0]) * 64'(item_b0_ff.ay_mag);
      hi_x_b1_in = 65'(item_b0_ff.num_mag[64:32]) * 65'(item_b0_ff.ax_mag);
      hi_y_b1_in = 65'(item_b0_ff.num_mag[64:32]) * 65'(item_b0_ff.ay_mag);
   end

   // recombine halves
   always_comb begin
      prod_x_b2_in = PW'({hi_x_b1_ff, 32'd0}) + PW'(lo_x_b1_ff);
      prod_y_b2_in = PW'({hi_y_b1_ff, 32'd0}) + PW'(lo_y_b1_ff);
   end

   // divider lanes: quotient at or above 2^41 saturates up front
   always_comb begin
      lane_x_in[0].rem = DTW'(prod_x_b2_ff[PW-1:QB]);
      lane_x_in[0].low = prod_x_b2_ff[QB-1:0];
      lane_x_in[0].quo = '0;
      lane_x_in[0].p   = item_b2_ff.p1x;
      lane_x_in[0].neg = item_b2_ff.neg_x;
      lane_x_in[0].sat = DTW'(prod_x_b2_ff[PW-1:QB]) >= item_b2_ff.det_mag;
      lane_y_in[0].rem = DTW'(prod_y_b2_ff[PW-1:QB]);
      lane_y_in[0].low = prod_y_b2_ff[QB-1:0];
      lane_y_in[0].quo = '0;
      lane_y_in[0].p   = item_b2_ff.p1y;
      lane_y_in[0].neg = item_b2_ff.neg_y;
      lane_y_in[0].sat = DTW'(prod_y_b2_ff[PW-1:QB]) >= item_b2_ff.det_mag;
      dvs_in[0]        = item_b2_ff.det_mag;
      dpar_in[0]       = item_b2_ff.par;
      dvld_in[0]       = vld_b2_ff;
      for (int k = 1; k <= QB; k++) begin
         lane_x_in[k] = div_step(lane_x_ff[k-1], dvs_ff[k-1]);
         lane_y_in[k] = div_step(lane_y_ff[k-1], dvs_ff[k-1]);
         dvs_in[k]    = dvs_ff[k-1];
         dpar_in[k]   = dpar_ff[k-1];
         dvld_in[k]   = dvld_ff[k-1];
      end
   end

   // final add, saturation and parallel override
   always_comb begin
      fin_x = finish(lane_x_ff[QB]);
      fin_y = finish(lane_y_ff[QB]);
      if (dpar_ff[QB]) begin
         cross_x_in = NEG_ONE;
         cross_y_in = NEG_ONE;
         ovf_in     = 1'b0;
      end else begin
         cross_x_in = fin_x[DW-1:0];
         cross_y_in = fin_y[DW-1:0];
         ovf_in     = fin_x[DW] | fin_y[DW];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_b0_ff  <= 1'b0;
         vld_b1_ff  <= 1'b0;
         vld_b2_ff  <= 1'b0;
         dvld_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_b0_ff  <= pop_valid;
         vld_b1_ff  <= vld_b0_ff;
         vld_b2_ff  <= vld_b1_ff;
         dvld_ff    <= dvld_in;
         out_vld_ff <= dvld_ff[QB];
      end
   end

   // payload pipe
   always_ff @(posedge clock) begin
      if (adv) begin
         item_b0_ff   <= pop_item;
         item_b1_ff   <= item_b0_ff;
         item_b2_ff   <= item_b1_ff;
         lo_x_b1_ff   <= lo_x_b1_in;
         lo_y_b1_ff   <= lo_y_b1_in;
         hi_x_b1_ff   <= hi_x_b1_in;
         hi_y_b1_ff   <= hi_y_b1_in;
         prod_x_b2_ff <= prod_x_b2_in;
         prod_y_b2_ff <= prod_y_b2_in;
         dpar_ff      <= dpar_in;
         for (int k = 0; k <= QB; k++) begin
            lane_x_ff[k] <= lane_x_in[k];
            lane_y_ff[k] <= lane_y_in[k];
            dvs_ff[k]    <= dvs_in[k];
         end
         cross_x_ff   <= cross_x_in;
         cross_y_ff   <= cross_y_in;
         par_ff       <= dpar_ff[QB];
         ovf_ff       <= ovf_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/lip_checker.sv =====
// ----------------------------------------------------------------------------
// lip_checker
// Port-level checks on the result channel of the intersection core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "line_intersection_point_core_assert.svh"

module lip_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] cross_x,
   input logic [31:0] cross_y,
   input logic        is_parallel,
   input logic        overflowed
);

   // a stalled result beat keeps its contents
   `LIP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(cross_x) && $stable(cross_y) && $stable(is_parallel) && $stable(overflowed), "rsp beat changed while stalled")

   // parallel lines report the same negative point and no overflow
   `LIP_ASSERT(a_par_point, clock, reset, rsp_valid && is_parallel |-> !overflowed && cross_x == cross_y && cross_x[31], "parallel result malformed")

   // overflow means a coordinate sits at a limit
   `LIP_ASSERT(a_ovf_limit, clock, reset, rsp_valid && overflowed |-> cross_x == 32'h7FFF_FFFF || cross_x == 32'h8000_0000 || cross_y == 32'h7FFF_FFFF || cross_y == 32'h8000_0000, "overflow flag without saturated coordinate")

   // reset leaves no result pending
   `LIP_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "rsp valid right after reset")

endmodule

bind line_intersection_point_core lip_checker u_lip_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .cross_x    (rsp.cross_x),
   .cross_y    (rsp.cross_y),
   .is_parallel(rsp.is_parallel),
   .overflowed (rsp.overflowed)
);

`default_nettype wire
